### hw/rtl/dhf_pkg.sv
// Shared types, constants and the CRC-16/X-25 byte step for the header framer.
`timescale 1ns / 1ps

package dhf_pkg;

  localparam int unsigned HDR_BYTES = 8;
  localparam int unsigned HDR_IDX_W = $clog2(HDR_BYTES);
  // Last header byte that is folded into the CRC (the length low byte)
  localparam int unsigned HDR_CRC_LAST_IDX = 5;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_REFL = 16'h8408;
  localparam logic [15:0] CRC_XOROUT    = 16'hFFFF;

  localparam logic [15:0] FRAME_LIMIT_RESET = 16'd1500;
  localparam logic [31:0] CHANNEL_ID_RESET  = 32'd0;

  // Input item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_FRAME_LIMIT = 1'b0,
    CFG_CHANNEL_ID  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic        load;     // open a header, byte 0 already sent
    logic        advance;  // current header byte is taken
    logic [31:0] id;
    logic [15:0] len;
  } hdr_ctrl_t;

  typedef struct packed {
    logic       active;    // header bytes still to send
    logic [7:0] data;      // current header byte
    logic       last;      // current byte closes a zero-length frame
  } hdr_stat_t;

  // One byte through the reflected CRC-16/X-25 register.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/datagram_header_framer_crc16.sv
// Top level of the datagram header framer with CRC-16/X-25 header check.
// The first result of an accepted request is in the output register in the next cycle.
// A payload or error request yields one output byte at most; a start opens the header,
//   and input is held off while header bytes 2 to 8 are sequenced by the header unit.
// Output stalls hold the output register and back-pressure the input in the same cycle.
// Reset: synchronous; clears the open frame, the output valid flag and the header unit,
//   and returns frame_limit to 1500 and channel_id to 0.
`timescale 1ns / 1ps

module datagram_header_framer_crc16 (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // payload_length[15:0], payload_byte[23:16]
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // frame_byte[7:0]
  output logic        m_tlast,   // frame_end
  output logic        m_tuser    // too_long
);

  logic [15:0] frame_limit;
  logic [31:0] channel_id;
  logic        frame_open;
  logic [15:0] bytes_left;

  logic        out_free;
  logic        accept;
  logic        kind;
  logic [15:0] req_len;
  logic [7:0]  req_byte;
  logic [15:0] room;
  logic        too_long;

  dhf_pkg::hdr_ctrl_t hctrl;
  dhf_pkg::hdr_stat_t hstat;

  assign kind     = s_tuser;
  assign req_len  = s_tdata[15:0];
  assign req_byte = s_tdata[23:16];

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = out_free && !hstat.active;
  assign accept   = s_tvalid && s_tready;

  assign room     = (frame_limit >= 16'(dhf_pkg::HDR_BYTES))
                  ? frame_limit - 16'(dhf_pkg::HDR_BYTES) : 16'd0;
  assign too_long = req_len > room;

  assign hctrl.load    = accept && (kind == dhf_pkg::KIND_START) && !too_long;
  assign hctrl.advance = out_free && hstat.active;
  assign hctrl.id      = channel_id;
  assign hctrl.len     = req_len;

  dhf_hdr_gen u_hdr_gen (
    .clk  (clk),
    .rst  (rst),
    .ctrl (hctrl),
    .stat (hstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= dhf_pkg::FRAME_LIMIT_RESET;
      channel_id  <= dhf_pkg::CHANNEL_ID_RESET;
      frame_open  <= 1'b0;
      bytes_left  <= 16'd0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (dhf_pkg::cfg_index_t'(cfg_index))
          dhf_pkg::CFG_FRAME_LIMIT: frame_limit <= cfg_data[15:0];
          dhf_pkg::CFG_CHANNEL_ID:  channel_id  <= cfg_data;
          default: ;
        endcase
      end

      if (out_free) begin
        m_tvalid <= 1'b0;
      end

      if (accept) begin
        if (kind == dhf_pkg::KIND_START) begin
          // a new start abandons any open frame
          frame_open <= 1'b0;
          bytes_left <= 16'd0;
          m_tvalid   <= 1'b1;
          if (too_long) begin
            m_tdata <= 8'h00;
            m_tlast <= 1'b1;
            m_tuser <= 1'b1;
          end else begin
            m_tdata <= channel_id[31:24];
            m_tlast <= 1'b0;
            m_tuser <= 1'b0;
            if (req_len != 16'd0) begin
              frame_open <= 1'b1;
              bytes_left <= req_len;
            end
          end
        end else if (!frame_open || bytes_left == 16'd0) begin
          // drop a payload byte with no frame open
          frame_open <= 1'b0;
          bytes_left <= 16'd0;
        end else begin
          bytes_left <= bytes_left - 16'd1;
          m_tvalid   <= 1'b1;
          m_tdata    <= req_byte;
          m_tlast    <= (bytes_left == 16'd1);
          m_tuser    <= 1'b0;
          if (bytes_left == 16'd1) begin
            frame_open <= 1'b0;
          end
        end
      end else if (hctrl.advance) begin
        m_tvalid <= 1'b1;
        m_tdata  <= hstat.data;
        m_tlast  <= hstat.last;
        m_tuser  <= 1'b0;
      end
    end
  end

  a_hold_input_in_header : assert property (@(posedge clk) disable iff (rst)
    hstat.active |-> !s_tready)
    else $error("input taken while header bytes are pending");

  a_load_when_idle : assert property (@(posedge clk) disable iff (rst)
    hctrl.load |-> !hstat.active)
    else $error("header load while a header is in flight");

  a_first_header_byte : assert property (@(posedge clk) disable iff (rst)
    hctrl.load |=> (m_tvalid && !m_tlast && !m_tuser && m_tdata == $past(channel_id[31:24])))
    else $error("first header byte missing after start");

  a_error_closes : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == 8'h00))
    else $error("error result not marked as frame end");

  a_open_matches_count : assert property (@(posedge clk) disable iff (rst)
    frame_open == (bytes_left != 16'd0))
    else $error("frame open flag disagrees with remaining byte count");

endmodule

### hw/rtl/dhf_hdr_gen.sv
// Header byte sequencer: steps through id, length and CRC, one byte each time the current byte is taken.
`timescale 1ns / 1ps

module dhf_hdr_gen (
  input  logic               clk,
  input  logic               rst,
  input  dhf_pkg::hdr_ctrl_t ctrl,
  output dhf_pkg::hdr_stat_t stat
);

  logic                          active;
  logic [dhf_pkg::HDR_IDX_W-1:0] idx;
  logic [15:0]                   crc;
  logic [31:0]                   id;
  logic [15:0]                   len;
  logic [7:0]                    cur_byte;
  logic [15:0]                   crc_out;

  assign crc_out = crc ^ dhf_pkg::CRC_XOROUT;

  always_comb begin
    case (idx)
      3'd0:    cur_byte = id[31:24];
      3'd1:    cur_byte = id[23:16];
      3'd2:    cur_byte = id[15:8];
      3'd3:    cur_byte = id[7:0];
      3'd4:    cur_byte = len[15:8];
      3'd5:    cur_byte = len[7:0];
      3'd6:    cur_byte = crc_out[15:8];
      default: cur_byte = crc_out[7:0];
    endcase
  end

  assign stat.active = active;
  assign stat.data   = cur_byte;
  assign stat.last   = (idx == 3'(dhf_pkg::HDR_BYTES - 1)) && (len == 16'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (ctrl.load) begin
      active <= 1'b1;
      idx    <= 3'd1;
      crc    <= dhf_pkg::crc_byte(dhf_pkg::CRC_INIT, ctrl.id[31:24]);
      id     <= ctrl.id;
      len    <= ctrl.len;
    end else if (ctrl.advance && active) begin
      // fold id and length bytes into the CRC as they go out
      if (idx <= 3'(dhf_pkg::HDR_CRC_LAST_IDX)) begin
        crc <= dhf_pkg::crc_byte(crc, cur_byte);
      end
      if (idx == 3'(dhf_pkg::HDR_BYTES - 1)) begin
        active <= 1'b0;
      end
      idx <= idx + 3'd1;
    end
  end

endmodule

### bench/tb_datagram_header_framer_crc16.sv
// Self-checking bench for the datagram header framer: directed table, random frames, scoreboard.
`timescale 1ns / 1ps

module tb_datagram_header_framer_crc16;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } frame_out_t;

  typedef enum logic [1:0] {ROW_START, ROW_DATA, ROW_CFG} row_op_t;
  // How a row's results are known: from the predictor, or typed in
  typedef enum logic [1:0] {FIX_PRED, FIX_EMPTY, FIX_ERR, FIX_LAST} row_fix_t;

  typedef struct {
    row_op_t             op;
    dhf_pkg::cfg_index_t idx;
    logic [31:0]         val;
    row_fix_t            fix;
  } plan_row_t;

  localparam int PLAN_ROWS     = 30;
  localparam int RAND_ITEMS    = 336;
  localparam int PHASE_ITEMS   = 72;
  localparam int SETTLE_CYCLES = 12;
  localparam int IDLE_PCT      = 21;
  localparam int MAX_RAND_LEN  = 12;
  localparam logic [15:0] HEADER_LEN = 16'd8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // payload_length[15:0], payload_byte[23:16]
  logic        s_tuser = 1'b0; // kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // frame_byte[7:0]
  logic        m_tlast;        // frame_end
  logic        m_tuser;        // too_long

  row_fix_t    req_fix = FIX_PRED;
  logic        steady = 1'b0;
  int          mismatches = 0;

  // Mirror of the framer's registers and frame state
  logic [15:0] limit_m = 16'd1500;
  logic [31:0] chan_m = 32'd0;
  logic        open_m = 1'b0;
  logic [15:0] left_m = 16'd0;

  frame_out_t  step_out [8];
  int          step_n;
  frame_out_t  frame_due [$];
  plan_row_t   plan [PLAN_ROWS];

  datagram_header_framer_crc16 DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  // Bit-serial X-25 check over the six header bytes, first byte in the top bits
  function automatic logic [15:0] x25_header_check(input logic [47:0] msg);
    logic [15:0] acc;
    logic        fb;
    int          b;
    int          j;
    acc = 16'hFFFF;
    for (b = 5; b >= 0; b--) begin
      for (j = 0; j < 8; j++) begin
        fb  = acc[0] ^ msg[8 * b + j];
        acc = acc >> 1;
        if (fb) begin
          acc = acc ^ 16'h8408;
        end
      end
    end
    return ~acc;
  endfunction

  task automatic frame_predict(input logic kind, input logic [15:0] len, input logic [7:0] pb);
    logic [15:0] room;
    logic [15:0] check;
    logic [63:0] hdr;
    int          k;
    step_n = 0;
    if (kind == dhf_pkg::KIND_START) begin
      room   = (limit_m >= HEADER_LEN) ? limit_m - HEADER_LEN : 16'd0;
      open_m = 1'b0;
      left_m = 16'd0;
      if (len > room) begin
        step_out[0] = '{8'h00, 1'b1, 1'b1};
        step_n = 1;
      end else begin
        check = x25_header_check({chan_m, len});
        hdr   = {chan_m, len, check};
        for (k = 0; k < 8; k++) begin
          step_out[k] = '{hdr[63 - 8 * k -: 8], (k == 7) && (len == 16'd0), 1'b0};
        end
        step_n = 8;
        if (len != 16'd0) begin
          open_m = 1'b1;
          left_m = len;
        end
      end
    end else if (!open_m || left_m == 16'd0) begin
      // drop: no frame waiting
      open_m = 1'b0;
      left_m = 16'd0;
    end else begin
      left_m = left_m - 16'd1;
      if (left_m == 16'd0) begin
        open_m = 1'b0;
      end
      step_out[0] = '{pb, left_m == 16'd0, 1'b0};
      step_n = 1;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : scoreboard
    frame_out_t got;
    frame_out_t want;
    int         k;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata, m_tlast, m_tuser};
        if (frame_due.size() == 0) begin
          report_mismatch("unexpected frame byte", got.data, 0);
        end else begin
          want = frame_due.pop_front();
          if (got.data !== want.data) report_mismatch("frame_byte", got.data, want.data);
          if (got.last !== want.last) report_mismatch("frame_end", got.last, want.last);
          if (got.err !== want.err) report_mismatch("too_long", got.err, want.err);
        end
      end
      if (s_tvalid && s_tready) begin
        frame_predict(s_tuser, s_tdata[15:0], s_tdata[23:16]);
        case (req_fix)
          FIX_PRED: begin
            for (k = 0; k < step_n; k++) frame_due.push_back(step_out[k]);
          end
          FIX_ERR: begin
            frame_due.push_back('{8'h00, 1'b1, 1'b1});
          end
          FIX_LAST: begin
            frame_due.push_back('{s_tdata[23:16], 1'b1, 1'b0});
          end
          default: ;
        endcase
      end
    end
  end

  always @(negedge clk) begin
    m_tready = steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic kind, input logic [15:0] len, input logic [7:0] pb,
                              input row_fix_t fx);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = kind;
    s_tdata  = {pb, len};
    req_fix  = fx;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_start(input logic [15:0] len);
    send_request(dhf_pkg::KIND_START, len, 8'($urandom_range(0, 255)), FIX_PRED);
  endtask

  task automatic send_data(input logic [7:0] pb);
    send_request(dhf_pkg::KIND_DATA, 16'($urandom_range(0, 65535)), pb, FIX_PRED);
  endtask

  // Write only once the framer has gone quiet
  task automatic write_reg(input dhf_pkg::cfg_index_t idx, input logic [31:0] val);
    s_tvalid = 1'b0;
    while (frame_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    if (idx == dhf_pkg::CFG_FRAME_LIMIT) begin
      limit_m = val[15:0];
    end else begin
      chan_m = val;
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin : stimulus
    int          r;
    int          i;
    int          ph;
    int          len;
    int          room;
    int          cap;
    int          pick;
    int          cut;
    int          rand_sent;
    int          phase_end;
    logic [15:0] lim;

    plan = '{
      '{ROW_DATA,  dhf_pkg::CFG_FRAME_LIMIT, 32'h0000_00A5, FIX_EMPTY},
      '{ROW_START, dhf_pkg::CFG_FRAME_LIMIT, 32'd0,         FIX_PRED},
      '{ROW_START, dhf_pkg::CFG_FRAME_LIMIT, 32'd3,         FIX_PRED},
      '{ROW_DATA,  dhf_pkg::CFG_FRAME_LIMIT, 32'h0000_0000, FIX_PRED},
      '{ROW_DATA,  dhf_pkg::CFG_FRAME_LIMIT, 32'h0000_00FF, FIX_PRED},
      '{ROW_DATA,  dhf_pkg::CFG_FRAME_LIMIT, 32'h0000_005A, FIX_LAST},
      '{ROW_DATA,  dhf_pkg::CFG_FRAME_LIMIT, 32'h0000_0011, FIX_EMPTY},
      '{ROW_START, dhf_pkg::CFG_FRAME_LIMIT, 32'd1492,      FIX_PRED},
      '{ROW_DATA,  dhf_pkg::CFG_FRAME_LIMIT, 32'h0000_003C, FIX_PRED},
      '{ROW_START, dhf_pkg::CFG_FRAME_LIMIT, 32'd1493,      FIX_ERR},
      '{ROW_DATA,  dhf_pkg::CFG_FRAME_LIMIT, 32'h0000_0077, FIX_EMPTY},
      '{ROW_START, dhf_pkg::CFG_FRAME_LIMIT, 32'd65535,     FIX_ERR},
      '{ROW_CFG,   dhf_pkg::CFG_FRAME_LIMIT, 32'd7,         FIX_PRED},
      '{ROW_CFG,   dhf_pkg::CFG_CHANNEL_ID,  32'hFFFF_FFFF, FIX_PRED},
      '{ROW_START, dhf_pkg::CFG_FRAME_LIMIT, 32'd0,         FIX_PRED},
      '{ROW_START, dhf_pkg::CFG_FRAME_LIMIT, 32'd1,         FIX_ERR},
      '{ROW_CFG,   dhf_pkg::CFG_FRAME_LIMIT, 32'd8,         FIX_PRED},
      '{ROW_START, dhf_pkg::CFG_FRAME_LIMIT, 32'd0,         FIX_PRED},
      '{ROW_START, dhf_pkg::CFG_FRAME_LIMIT, 32'd1,         FIX_ERR},
      '{ROW_CFG,   dhf_pkg::CFG_FRAME_LIMIT, 32'd0,         FIX_PRED},
      '{ROW_START, dhf_pkg::CFG_FRAME_LIMIT, 32'd0,         FIX_PRED},
      '{ROW_START, dhf_pkg::CFG_FRAME_LIMIT, 32'd65535,     FIX_ERR},
      '{ROW_CFG,   dhf_pkg::CFG_FRAME_LIMIT, 32'd65535,     FIX_PRED},
      '{ROW_CFG,   dhf_pkg::CFG_CHANNEL_ID,  32'h1234_5678, FIX_PRED},
      '{ROW_START, dhf_pkg::CFG_FRAME_LIMIT, 32'd65527,     FIX_PRED},
      '{ROW_DATA,  dhf_pkg::CFG_FRAME_LIMIT, 32'h0000_00C3, FIX_PRED},
      '{ROW_START, dhf_pkg::CFG_FRAME_LIMIT, 32'd2,         FIX_PRED},
      '{ROW_DATA,  dhf_pkg::CFG_FRAME_LIMIT, 32'h0000_0081, FIX_PRED},
      '{ROW_DATA,  dhf_pkg::CFG_FRAME_LIMIT, 32'h0000_007E, FIX_LAST},
      '{ROW_START, dhf_pkg::CFG_FRAME_LIMIT, 32'd65528,     FIX_ERR}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (r = 0; r < PLAN_ROWS; r++) begin
      case (plan[r].op)
        ROW_CFG: begin
          write_reg(plan[r].idx, plan[r].val);
        end
        ROW_START: begin
          send_request(dhf_pkg::KIND_START, plan[r].val[15:0], 8'($urandom_range(0, 255)),
                       plan[r].fix);
        end
        default: begin
          send_request(dhf_pkg::KIND_DATA, 16'($urandom_range(0, 65535)), plan[r].val[7:0],
                       plan[r].fix);
        end
      endcase
    end

    rand_sent = 0;
    for (ph = 0; rand_sent < RAND_ITEMS; ph++) begin
      case (ph % 5)
        0:       lim = 16'($urandom_range(8, 40));
        1:       lim = 16'hFFFF;
        2:       lim = 16'($urandom_range(0, 7));
        3:       lim = 16'($urandom_range(9, 20));
        default: lim = 16'($urandom_range(0, 65535));
      endcase
      write_reg(dhf_pkg::CFG_FRAME_LIMIT, {16'd0, lim});
      write_reg(dhf_pkg::CFG_CHANNEL_ID, $urandom);
      // one whole phase runs with both sides always ready
      steady = (ph % 5 == 1);
      room = (lim >= HEADER_LEN) ? lim - HEADER_LEN : 0;
      cap  = (room < MAX_RAND_LEN) ? room : MAX_RAND_LEN;
      phase_end = rand_sent + PHASE_ITEMS;
      while (rand_sent < phase_end && rand_sent < RAND_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          len = $urandom_range(0, cap);
          send_start(16'(len));
          for (i = 0; i < len; i++) send_data(8'($urandom_range(0, 255)));
          rand_sent += len + 1;
        end else if (pick < 85 && cap >= 2) begin
          // cut the frame short; the next start abandons it
          len = $urandom_range(2, cap);
          cut = $urandom_range(0, len - 1);
          send_start(16'(len));
          for (i = 0; i < cut; i++) send_data(8'($urandom_range(0, 255)));
          rand_sent += cut + 1;
        end else if (pick < 93) begin
          send_start(16'($urandom_range(room + 1, 65535)));
          rand_sent++;
        end else begin
          send_data(8'($urandom_range(0, 255)));
          rand_sent++;
        end
      end
    end
    steady = 1'b0;

    s_tvalid = 1'b0;
    for (i = 0; i < 20000 && frame_due.size() != 0; i++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (frame_due.size() != 0) begin
      report_mismatch("frame bytes never arrived", frame_due.size(), 0);
    end
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/dhf_pkg.sv
hw/rtl/dhf_hdr_gen.sv
hw/rtl/datagram_header_framer_crc16.sv
bench/tb_datagram_header_framer_crc16.sv
